// ===== src/request_frame_builder_assert.svh =====
// Assertion helpers for the request frame builder.
`ifndef REQUEST_FRAME_BUILDER_ASSERT_SVH
`define REQUEST_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RFB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("request_frame_builder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("request_frame_builder: next-cycle check failed");

`endif

// ===== src/rfb_pkg.sv =====
package rfb_pkg;

  // Request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Fixed header bytes, checksum fold constant and length bias
  localparam logic [7:0] HDR_SYNC0 = 8'h00;
  localparam logic [7:0] HDR_SYNC1 = 8'hD7;
  localparam logic [7:0] HDR_SYNC2 = 8'h29;
  localparam logic [7:0] FOLD_XOR  = 8'h3C;
  localparam logic [7:0] LEN_BIAS  = 8'h01;

  // Byte positions within a start request
  localparam logic [2:0] STEP_SYNC0 = 3'd0;
  localparam logic [2:0] STEP_SYNC1 = 3'd1;
  localparam logic [2:0] STEP_SYNC2 = 3'd2;
  localparam logic [2:0] STEP_ADDR  = 3'd3;
  localparam logic [2:0] STEP_CMD   = 3'd4;
  localparam logic [2:0] STEP_LEN   = 3'd5;
  localparam logic [2:0] STEP_HSUM  = 3'd6;

  // Byte positions within a payload request
  localparam logic [2:0] STEP_DATA  = 3'd0;
  localparam logic [2:0] STEP_DSUM  = 3'd1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] dev_address;
    logic [7:0] command_code;
    logic [7:0] payload_count;
    logic [7:0] data_byte;
  } rfb_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } rfb_byte_t;

  // XOR in, rotate right by one, fold 0x3C when the top bit lands set
  function automatic logic [7:0] fold_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    c = {c[0], c[7:1]};
    if (c[7]) begin
      c = c ^ FOLD_XOR;
    end
    return c;
  endfunction

endpackage

// ===== src/rfb_req_if.sv =====
interface rfb_req_if import rfb_pkg::*;;
  logic     valid;
  logic     ready;
  rfb_req_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== src/rfb_byte_if.sv =====
interface rfb_byte_if import rfb_pkg::*;;
  logic      valid;
  logic      ready;
  rfb_byte_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== src/request_frame_builder.sv =====
// Channel  Dir  Moves
// req      in   request: opcode, dev_address, command_code, payload_count, data_byte
// tx       out  frame byte: out_byte, run_last, frame_end
//
// One frame byte leaves per cycle through the output register unless tx stalls.
// A start request yields six header bytes, plus the checksum for an empty payload;
// a payload request yields its data byte, plus the checksum when it closes the
// frame. A payload request with no open frame is taken and yields nothing. Reset
// is synchronous and clears all control state. A stall on tx holds the output and
// work registers; a new request is taken in the cycle the current one finishes.
`include "request_frame_builder_assert.svh"

module request_frame_builder import rfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rfb_req_if.sink    req,
  rfb_byte_if.source tx
);

  // Front-end frame tracking, updated when a request is taken
  logic       frame_open;
  logic [7:0] bytes_left;

  // Work register: the request whose bytes are being emitted
  logic       cur_valid;
  logic       cur_op;
  logic       cur_close;
  logic [2:0] step;
  logic [7:0] cur_addr;
  logic [7:0] cur_cmd;
  logic [7:0] cur_len;
  logic [7:0] cur_data;

  // Running checksum, lives with the emit side
  logic [7:0] acc;
  logic [7:0] acc_next;

  // Output register
  logic      out_valid;
  rfb_byte_t out_item;

  logic       out_free;
  logic       adv;
  logic       cur_last;
  logic       is_sum;
  logic       finish;
  logic       accept;
  logic       load_item;
  logic       is_start;
  logic [7:0] left_dec;
  logic [7:0] emit_byte;
  logic [7:0] base_acc;

  assign out_free  = !out_valid || tx.ready;
  assign adv       = cur_valid && out_free;
  assign finish    = adv && cur_last;
  assign req.ready = !cur_valid || finish;
  assign accept    = req.valid && req.ready;
  assign is_start  = (req.item.opcode == OP_START);
  assign left_dec  = bytes_left - LEN_BIAS;
  assign load_item = accept && (is_start || frame_open);

  // Byte selection and checksum fold for the current position
  always_comb begin
    emit_byte = HDR_SYNC0;
    is_sum    = 1'b0;
    cur_last  = 1'b0;
    base_acc  = acc;
    if (cur_op == OP_START) begin
      if (step == STEP_SYNC0) begin
        base_acc = '0;
      end
      case (step)
        STEP_SYNC0: emit_byte = HDR_SYNC0;
        STEP_SYNC1: emit_byte = HDR_SYNC1;
        STEP_SYNC2: emit_byte = HDR_SYNC2;
        STEP_ADDR:  emit_byte = cur_addr;
        STEP_CMD:   emit_byte = cur_cmd;
        STEP_LEN:   emit_byte = cur_len;
        STEP_HSUM:  begin
          emit_byte = acc;
          is_sum    = 1'b1;
        end
        default:    emit_byte = HDR_SYNC0;
      endcase
      cur_last = (step == STEP_HSUM) || ((step == STEP_LEN) && !cur_close);
    end else begin
      if (step == STEP_DSUM) begin
        emit_byte = acc;
        is_sum    = 1'b1;
      end else begin
        emit_byte = cur_data;
      end
      cur_last = (step == STEP_DSUM) || ((step == STEP_DATA) && !cur_close);
    end
    acc_next = is_sum ? '0 : fold_byte(base_acc, emit_byte);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= '0;
      cur_valid  <= 1'b0;
      step       <= '0;
      acc        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (is_start) begin
          frame_open <= (req.item.payload_count != '0);
          bytes_left <= req.item.payload_count;
        end else if (frame_open) begin
          frame_open <= (left_dec != '0);
          bytes_left <= left_dec;
        end
      end
      if (load_item) begin
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end else if (adv) begin
        step <= step + 3'd1;
      end
      if (adv) begin
        acc <= acc_next;
      end
      if (out_free) begin
        out_valid <= adv;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load_item) begin
      cur_op    <= req.item.opcode;
      cur_addr  <= req.item.dev_address;
      cur_cmd   <= req.item.command_code;
      cur_len   <= req.item.payload_count + LEN_BIAS;
      cur_data  <= req.item.data_byte;
      cur_close <= is_start ? (req.item.payload_count == '0) : (left_dec == '0);
    end
    if (adv) begin
      out_item.out_byte  <= emit_byte;
      out_item.run_last  <= cur_last;
      out_item.frame_end <= is_sum;
    end
  end

  assign tx.valid = out_valid;
  assign tx.item  = out_item;

  // Checks
  `RFB_ASSERT_NOW(a_sum_is_last, clk, rst, tx.valid && tx.item.frame_end, tx.item.run_last)
  `RFB_ASSERT_NEXT(a_sum_clears_acc, clk, rst, adv && is_sum, acc == '0)
  `RFB_ASSERT_NOW(a_step_range, clk, rst, cur_valid && (cur_op == OP_DATA), step <= STEP_DSUM)
  `RFB_ASSERT_NEXT(a_stall_holds_work, clk, rst, cur_valid && !out_free, cur_valid && $stable(step))

endmodule

// ===== tb/sv/request_frame_builder_tb.sv =====
module request_frame_builder_tb import rfb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_ITEMS   = 410;
  localparam int DRAIN_CYCLES = 20;
  localparam int ERR_SHOWN    = 10;

  // Directed row: the request plus, where it is obvious, the bytes it must produce.
  // n_typed < 0 means the expected bytes come from the frame predictor.
  typedef struct {
    rfb_req_t        req;
    int              n_typed;
    logic [0:6][7:0] typed;
  } dir_row_t;

  logic clk;
  logic rst;

  rfb_req_if  req_ch ();
  rfb_byte_if tx_ch ();

  request_frame_builder dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .tx (tx_ch.source)
  );

  // Frame predictor state
  logic [7:0] chk_run;
  logic [7:0] pay_left;
  logic       in_frame;

  rfb_byte_t  bytes_due[$];
  dir_row_t   dir_tab[$];
  int         error_cnt;
  int         sent_cnt;
  int         send_idle_pct;
  int         stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Checksum step: xor in, rotate right, fold when the top bit ends up set
  function automatic logic [7:0] mix_in(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] x;
    x = acc ^ b;
    x = {x[0], x[7:1]};
    if (x[7]) begin
      x = x ^ FOLD_XOR;
    end
    return x;
  endfunction

  function automatic rfb_byte_t mk_byte(input logic [7:0] v, input logic is_end);
    rfb_byte_t b;
    b.out_byte  = v;
    b.run_last  = 1'b0;
    b.frame_end = is_end;
    return b;
  endfunction

  // Bytes on the wire caused by one request; advances the predictor state
  function automatic void predict_bytes(input rfb_req_t r, output rfb_byte_t res[$]);
    logic [7:0] hdr[6];
    res.delete();
    if (r.opcode == OP_START) begin
      hdr = '{HDR_SYNC0, HDR_SYNC1, HDR_SYNC2, r.dev_address, r.command_code,
              8'(r.payload_count + LEN_BIAS)};
      chk_run = 8'h00;
      foreach (hdr[i]) begin
        res.push_back(mk_byte(hdr[i], 1'b0));
        chk_run = mix_in(chk_run, hdr[i]);
      end
      if (r.payload_count == 8'd0) begin
        res.push_back(mk_byte(chk_run, 1'b1));
        in_frame = 1'b0;
        pay_left = 8'd0;
        chk_run  = 8'h00;
      end else begin
        in_frame = 1'b1;
        pay_left = r.payload_count;
      end
    end else if (in_frame) begin
      res.push_back(mk_byte(r.data_byte, 1'b0));
      chk_run  = mix_in(chk_run, r.data_byte);
      pay_left = pay_left - 8'd1;
      if (pay_left == 8'd0) begin
        res.push_back(mk_byte(chk_run, 1'b1));
        in_frame = 1'b0;
        chk_run  = 8'h00;
      end
    end
    // a dropped payload request leaves everything as it was
    if (res.size() > 0) begin
      res[res.size() - 1].run_last = 1'b1;
    end
  endfunction

  function automatic void log_error(input string msg);
    error_cnt++;
    if (error_cnt <= ERR_SHOWN) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endfunction

  function automatic dir_row_t mk_row(input logic op, input logic [7:0] addr, cmd, cnt, dat,
                                      input int n, input logic [0:6][7:0] bytes);
    dir_row_t row;
    row.req.opcode        = op;
    row.req.dev_address   = addr;
    row.req.command_code  = cmd;
    row.req.payload_count = cnt;
    row.req.data_byte     = dat;
    row.n_typed           = n;
    row.typed             = bytes;
    return row;
  endfunction

  // Present one request, wait for the handshake, queue its expected bytes
  task automatic send_request(input rfb_req_t r, input int n_typed,
                              input logic [0:6][7:0] typed);
    rfb_byte_t due[$];
    rfb_byte_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.item  <= r;
    do @(posedge clk); while (!req_ch.ready);
    predict_bytes(r, due);
    if (n_typed >= 0) begin
      due.delete();
      for (int i = 0; i < n_typed; i++) begin
        b = mk_byte(typed[i], 1'b0);
        b.run_last = (i == n_typed - 1);
        due.push_back(b);
      end
    end
    foreach (due[i]) bytes_due.push_back(due[i]);
    sent_cnt++;
  endtask

  task automatic send_rand_request(input logic op, input logic [7:0] cnt);
    rfb_req_t r;
    r.opcode        = op;
    r.dev_address   = 8'($urandom_range(0, 255));
    r.command_code  = 8'($urandom_range(0, 255));
    r.payload_count = cnt;
    r.data_byte     = 8'($urandom_range(0, 255));
    send_request(r, -1, '0);
  endtask

  // Mostly complete frames; some cut short (abandoned by the next start),
  // some with extra payload that must be dropped. Payload is trimmed to the
  // requests still left in the phase.
  task automatic send_rand_frame(input int room);
    int         pick;
    int         n_pay;
    logic [7:0] cnt;
    pick = $urandom_range(99);
    if (pick < 65) cnt = 8'($urandom_range(0, 6));
    else if (pick < 97) cnt = 8'($urandom_range(7, 30));
    else cnt = 8'($urandom_range(120, 255));
    send_rand_request(OP_START, cnt);
    n_pay = cnt;
    pick  = $urandom_range(99);
    if (pick < 6) n_pay = $urandom_range(0, cnt);
    else if (pick < 12) n_pay = cnt + $urandom_range(1, 3);
    if (n_pay > room - 1) n_pay = room - 1;
    repeat (n_pay) send_rand_request(OP_DATA, 8'($urandom_range(0, 255)));
  endtask

  // Output side: random back-pressure and in-order compare
  initial begin
    rfb_byte_t want;
    tx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tx_ch.valid && tx_ch.ready) begin
        if (bytes_due.size() == 0) begin
          log_error($sformatf("unexpected byte %02h last=%0b end=%0b", tx_ch.item.out_byte,
                              tx_ch.item.run_last, tx_ch.item.frame_end));
        end else begin
          want = bytes_due.pop_front();
          if (tx_ch.item.out_byte !== want.out_byte || tx_ch.item.run_last !== want.run_last ||
              tx_ch.item.frame_end !== want.frame_end) begin
            log_error($sformatf("byte/last/end expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                want.out_byte, want.run_last, want.frame_end,
                                tx_ch.item.out_byte, tx_ch.item.run_last, tx_ch.item.frame_end));
          end
        end
      end
      tx_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus
  initial begin
    int target;
    error_cnt     = 0;
    sent_cnt      = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    chk_run       = 8'h00;
    pay_left      = 8'd0;
    in_frame      = 1'b0;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.item  <= '0;

    // payload with no frame open is dropped
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hA5, 0, '0));
    // empty frames at both extremes of address and command
    dir_tab.push_back(mk_row(OP_START, 8'h00, 8'h00, 8'd0, 8'h00, -1, '0));
    dir_tab.push_back(mk_row(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, '0));
    dir_tab.push_back(mk_row(OP_START, 8'hFF, 8'hFF, 8'd0, 8'hFF, -1, '0));
    // count 255: length byte wraps to zero
    dir_tab.push_back(mk_row(OP_START, 8'hFF, 8'h00, 8'd255, 8'h00, 6,
                             {HDR_SYNC0, HDR_SYNC1, HDR_SYNC2, 8'hFF, 8'h00, 8'h00, 8'h00}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 1, {8'h00, 48'h0}));
    // new start abandons the open frame
    dir_tab.push_back(mk_row(OP_START, 8'h00, 8'hFF, 8'd254, 8'hFF, 6,
                             {HDR_SYNC0, HDR_SYNC1, HDR_SYNC2, 8'h00, 8'hFF, 8'hFF, 8'h00}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF, 1, {8'hFF, 48'h0}));
    // one-byte frame
    dir_tab.push_back(mk_row(OP_START, 8'h5A, 8'hC3, 8'd1, 8'h00, 6,
                             {HDR_SYNC0, HDR_SYNC1, HDR_SYNC2, 8'h5A, 8'hC3, 8'h02, 8'h00}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h3C, -1, '0));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h12, 0, '0));
    // three-byte frame
    dir_tab.push_back(mk_row(OP_START, 8'h81, 8'h7E, 8'd3, 8'h00, 6,
                             {HDR_SYNC0, HDR_SYNC1, HDR_SYNC2, 8'h81, 8'h7E, 8'h04, 8'h00}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h80, 1, {8'h80, 48'h0}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h01, 1, {8'h01, 48'h0}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h55, -1, '0));
    // two-byte frame
    dir_tab.push_back(mk_row(OP_START, 8'h01, 8'h80, 8'd2, 8'h00, 6,
                             {HDR_SYNC0, HDR_SYNC1, HDR_SYNC2, 8'h01, 8'h80, 8'h03, 8'h00}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hAA, 1, {8'hAA, 48'h0}));
    dir_tab.push_back(mk_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h7F, -1, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].n_typed, dir_tab[i].typed);

    // Random frames over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 77;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct     = 13;
        end
      endcase
      target = dir_tab.size() + (ph + 1) * RAND_ITEMS / 4;
      while (sent_cnt < target) begin
        if ($urandom_range(99) < 12) send_rand_request(OP_DATA, 8'($urandom_range(0, 255)));
        else send_rand_frame(target - sent_cnt);
      end
    end
    req_ch.valid <= 1'b0;

    // Drain outstanding bytes, then watch for strays
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0 && bytes_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rfb_pkg.sv
src/rfb_req_if.sv
src/rfb_byte_if.sv
src/request_frame_builder.sv
tb/sv/request_frame_builder_tb.sv
